// ===== sv/key_debounce_click_long_press_defines.svh =====
// assertion macros used by the merge stage of the key debounce block
`ifndef KEY_DEBOUNCE_CLICK_LONG_PRESS_DEFINES_SVH
`define KEY_DEBOUNCE_CLICK_LONG_PRESS_DEFINES_SVH

// same-cycle implication, checked out of reset
`define KDCLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define KDCLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/kdclp_pkg.sv =====
// types and constants for the key debounce block
package kdclp_pkg;

  localparam int NUM_KEYS  = 2;
  localparam int TIME_W    = 32;
  localparam int TICKS_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_EN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_EN    = 2'd3;

  localparam logic [TICKS_W-1:0]  DEBOUNCE_RST   = 16'd20;
  localparam logic [TICKS_W-1:0]  LONG_PRESS_RST = 16'd1000;

  typedef struct packed {
    logic [TIME_W-1:0]   now;
    logic [NUM_KEYS-1:0] pressed_bits;
  } in_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0] click_bits;
    logic [NUM_KEYS-1:0] long_press_bits;
    logic [NUM_KEYS-1:0] stable_bits;
  } out_t;

  typedef struct packed {
    logic [TICKS_W-1:0] debounce_ticks;
    logic [TICKS_W-1:0] long_press_ticks;
  } lane_cfg_t;

  typedef struct packed {
    logic click;
    logic long_press;
    logic stable;
  } lane_out_t;

endpackage

// ===== sv/kdclp_lane.sv =====
// per-key debounce, click and long-press core
module kdclp_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              take,
  input  logic                              started,
  input  logic [kdclp_pkg::TIME_W-1:0]      now,
  input  logic                              sample,
  input  kdclp_pkg::lane_cfg_t              cfg,
  input  logic                              click_en,
  input  logic                              long_en,
  output kdclp_pkg::lane_out_t              res
);

  logic                         raw_r, raw_nxt;
  logic                         stable_r, stable_nxt;
  logic                         fired_r, fired_nxt;
  logic [kdclp_pkg::TIME_W-1:0] raw_time_r, raw_time_nxt;
  logic [kdclp_pkg::TIME_W-1:0] press_time_r, press_time_nxt;

  logic [kdclp_pkg::TIME_W-1:0] raw_age;
  logic [kdclp_pkg::TIME_W-1:0] press_age;
  logic                         changed;
  logic                         confirm;
  logic                         fire;
  logic                         click;

  assign raw_age   = now - raw_time_r;
  assign press_age = now - press_time_r;
  assign changed   = sample != raw_r;

  // a fresh raw change has age zero, which never meets a threshold of at least one
  assign confirm = !changed && (raw_r != stable_r) && (raw_age != '0) &&
                   (raw_age >= {{(kdclp_pkg::TIME_W-kdclp_pkg::TICKS_W){1'b0}},
                                cfg.debounce_ticks});
  assign click   = confirm && !raw_r && !fired_r && click_en;
  // a press confirmed on this item restarts the hold timer, so it cannot fire yet
  assign fire    = stable_r && !confirm && !fired_r && long_en && (press_age != '0) &&
                   (press_age >= {{(kdclp_pkg::TIME_W-kdclp_pkg::TICKS_W){1'b0}},
                                  cfg.long_press_ticks});

  always_comb begin
    raw_nxt        = raw_r;
    stable_nxt     = stable_r;
    fired_nxt      = fired_r;
    raw_time_nxt   = raw_time_r;
    press_time_nxt = press_time_r;
    res            = '0;
    if (!started) begin
      raw_nxt        = sample;
      stable_nxt     = sample;
      fired_nxt      = sample;
      raw_time_nxt   = now;
      press_time_nxt = now;
    end else begin
      raw_nxt = sample;
      if (changed) begin
        raw_time_nxt = now;
      end
      if (confirm) begin
        stable_nxt = raw_r;
        fired_nxt  = 1'b0;
        if (raw_r) begin
          press_time_nxt = now;
        end
      end
      if (fire) begin
        fired_nxt = 1'b1;
      end
      res.click      = click;
      res.long_press = fire;
    end
    res.stable = stable_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 1'b0;
      stable_r <= 1'b0;
      fired_r  <= 1'b0;
    end else if (take) begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      fired_r  <= fired_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      raw_time_r   <= raw_time_nxt;
      press_time_r <= press_time_nxt;
    end
  end

endmodule

// ===== sv/kdclp_merge.sv =====
// gathers lane results into one result item, with output register and skid entry
`include "key_debounce_click_long_press_defines.svh"

module kdclp_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  kdclp_pkg::lane_out_t lane_res [kdclp_pkg::NUM_KEYS],
  output logic                 out_valid,
  input  logic                 out_ready,
  output kdclp_pkg::out_t      out_data
);

  kdclp_pkg::out_t merged;
  kdclp_pkg::out_t out_r, out_nxt;
  kdclp_pkg::out_t skid_r, skid_nxt;
  logic            out_v_r, out_v_nxt;
  logic            skid_v_r, skid_v_nxt;
  logic            push;

  always_comb begin
    merged = '0;
    for (int k = 0; k < kdclp_pkg::NUM_KEYS; k++) begin
      merged.click_bits[k]      = lane_res[k].click;
      merged.long_press_bits[k] = lane_res[k].long_press;
      merged.stable_bits[k]     = lane_res[k].stable;
    end
  end

  assign in_ready = !skid_v_r;
  assign push     = in_valid && in_ready;

  always_comb begin
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else if (push) begin
        out_nxt   = merged;
        out_v_nxt = 1'b1;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (push) begin
      // receiver stalled: park the item behind the output register
      skid_nxt   = merged;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `KDCLP_ASSERT_IMP(a_skid_behind_out, skid_v_r, out_v_r, "skid holds an item with empty output")
  `KDCLP_ASSERT_NXT(a_stall_parks, push && out_v_r && !out_ready, skid_v_r, "stalled item not parked")
  `KDCLP_ASSERT_NXT(a_skid_holds, skid_v_r && !out_ready, skid_v_r && $stable(skid_r), "parked item changed")

endmodule

// ===== sv/key_debounce_click_long_press.sv =====
// top level of the key debounce block with click and long-press detection
//
// Input channel in_valid/in_ready/in_data carries one poll tick: a timestamp
// and one pressed bit per key. Output channel out_valid/out_ready/out_data
// returns one result item per tick: click pulses, long-press pulses and the
// debounced levels after the tick.
// Config port cfg_we/cfg_index/cfg_data writes debounce_ticks, long_press_ticks,
// click_enable and long_press_enable; write only while no item is in flight.
// Each result is registered in the output register, or in the skid entry while
// the receiver stalls. Throughput is one tick per cycle while the skid entry is
// empty; each key lane settles its state in the accept cycle with two 32-bit
// subtract-and-compare paths. Reset loads the register defaults and clears the
// key level and fired flags; the first tick then captures the key levels, and
// a key already held waits for its release. When the receiver stalls, one more
// tick is parked in a skid entry; in_ready drops only while that entry is full.
module key_debounce_click_long_press (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  kdclp_pkg::in_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output kdclp_pkg::out_t                   out_data,
  input  logic                              cfg_we,
  input  logic [kdclp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kdclp_pkg::CFG_W-1:0]       cfg_data
);

  kdclp_pkg::lane_cfg_t          lane_cfg_r;
  logic [kdclp_pkg::NUM_KEYS-1:0] click_en_r;
  logic [kdclp_pkg::NUM_KEYS-1:0] long_en_r;
  logic                           started_r;
  logic                           take;
  kdclp_pkg::lane_out_t           lane_res [kdclp_pkg::NUM_KEYS];

  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_cfg_r.debounce_ticks   <= kdclp_pkg::DEBOUNCE_RST;
      lane_cfg_r.long_press_ticks <= kdclp_pkg::LONG_PRESS_RST;
      click_en_r                  <= '0;
      long_en_r                   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        kdclp_pkg::CFG_DEBOUNCE:   lane_cfg_r.debounce_ticks   <= cfg_data;
        kdclp_pkg::CFG_LONG_PRESS: lane_cfg_r.long_press_ticks <= cfg_data;
        kdclp_pkg::CFG_CLICK_EN:   click_en_r <= cfg_data[kdclp_pkg::NUM_KEYS-1:0];
        kdclp_pkg::CFG_LONG_EN:    long_en_r  <= cfg_data[kdclp_pkg::NUM_KEYS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
    end else if (take) begin
      started_r <= 1'b1;
    end
  end

  for (genvar k = 0; k < kdclp_pkg::NUM_KEYS; k++) begin : g_lane
    kdclp_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .take     (take),
      .started  (started_r),
      .now      (in_data.now),
      .sample   (in_data.pressed_bits[k]),
      .cfg      (lane_cfg_r),
      .click_en (click_en_r[k]),
      .long_en  (long_en_r[k]),
      .res      (lane_res[k])
    );
  end

  kdclp_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .lane_res  (lane_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
